// ===== rtl/cyv_pkg.sv =====
// Shared types and constants for the Carreau-Yasuda viscosity unit.
// No dependencies; used by the stream interface, the top level and its checker.
package cyv_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FX_W       = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ETA_ZERO  = 3'd0,
    REG_ETA_INF   = 3'd1,
    REG_TIME_CONST = 3'd2,
    REG_YASUDA    = 3'd3,
    REG_POWER_IDX = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    DIV_LOAD,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic [FX_W-1:0] shear_rate;
  } in_t;

  typedef struct packed {
    logic [FX_W-1:0] viscosity;
    logic            saturated;
  } out_t;

endpackage

// ===== rtl/cyv_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on cyv_pkg for the default payload type.
interface cyv_stream_if
  import cyv_pkg::*;
#(
  parameter type payload_t = in_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/carreau_yasuda_viscosity_unit.sv =====
// The pipeline has 79 stages from an input transfer to its result on the output register.
// Throughput: one sample per cycle; the whole pipeline holds while a result waits.
// The exponent quotient (n-1)/a comes from a radix-2 divider: after reset and after
// any configuration write the input is held off while it runs.
// Reset (synchronous, active high) restores register defaults, clears valid bits
// and restarts the divider.
module carreau_yasuda_viscosity_unit
  import cyv_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cyv_stream_if.sink            sample,
  cyv_stream_if.source          result
);

  localparam int NSTG = 79;
  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [23:0] LX_OFF = 24'(2 * FRAC_BITS * 65536);
  localparam logic [30:0] R_ONE = 31'h4000_0000;
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic       pz;
    logic [5:0] m;
  } l1_side_t;

  typedef struct packed {
    logic        pz;
    logic [27:0] ypos;
    logic        uzero;
    logic        ufz;
    logic [5:0]  ui;
  } e1_side_t;

  typedef struct packed {
    logic        pz;
    logic [27:0] ypos;
    logic        m63;
  } l2_side_t;

  typedef struct packed {
    logic       left;
    logic       over;
    logic [5:0] amt;
  } e2_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    int          k;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [30:0] exp2_coef(input int j);
    logic [63:0] c;
    int          t;
    c = isqrt64(64'd2 << 60);
    for (t = 1; t < j; t++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

  function automatic logic [5:0] lod64(input logic [63:0] v);
    logic [5:0] m;
    int         k;
    m = '0;
    for (k = 0; k < 64; k++) begin
      if (v[k]) m = 6'(k);
    end
    return m;
  endfunction

  function automatic logic [32:0] log_step(input logic [31:0] z);
    logic [63:0] sq;
    sq = {32'b0, z} * {32'b0, z};
    if (sq[63]) return {1'b1, sq[63:32]};
    return {1'b0, sq[62:31]};
  endfunction

  function automatic logic [30:0] exp_step(input logic [30:0] r, input logic [30:0] c,
                                           input logic b);
    logic [61:0] pr;
    pr = {31'b0, r} * {31'b0, c};
    return b ? pr[60:30] : r;
  endfunction

  // configuration
  logic [31:0] eta_zero, eta_inf, time_constant;
  logic [15:0] yasuda_exponent;
  logic [14:0] power_index;
  logic [15:0] a_eff;
  logic [31:0] dmag;
  logic        dneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_zero        <= ONE_FX;
      eta_inf         <= '0;
      time_constant   <= ONE_FX;
      yasuda_exponent <= 16'd8192;
      power_index     <= 15'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ETA_ZERO:   eta_zero        <= cfg_data;
        REG_ETA_INF:    eta_inf         <= cfg_data;
        REG_TIME_CONST: time_constant   <= cfg_data;
        REG_YASUDA:     yasuda_exponent <= cfg_data[15:0];
        REG_POWER_IDX:  power_index     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_eff <= (yasuda_exponent == '0) ? 16'd1 : yasuda_exponent;
    dneg  <= eta_zero < eta_inf;
    dmag  <= (eta_zero < eta_inf) ? eta_inf - eta_zero : eta_zero - eta_inf;
  end

  // exponent quotient e = ((n - 1.0) << 16) / a, truncated toward zero
  div_state_t         div_state, div_state_next;
  logic [15:0]        div_rem;
  logic [30:0]        div_quo;
  logic [4:0]         div_cnt;
  logic               div_neg;
  logic signed [31:0] e_lq;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic [30:0]        quo_next;
  logic signed [15:0] nd;
  logic               div_ready;

  assign nd       = $signed({1'b0, power_index}) - 16'sd4096;
  assign rem_sh   = {div_rem, div_quo[30]};
  assign rem_ge   = rem_sh >= {1'b0, a_eff};
  assign quo_next = {div_quo[29:0], rem_ge};

  always_comb begin
    div_state_next = div_state;
    unique case (div_state)
      DIV_LOAD: div_state_next = DIV_RUN;
      DIV_RUN:  if (div_cnt == 5'd30) div_state_next = DIV_DONE;
      DIV_DONE: div_state_next = DIV_DONE;
      default:  div_state_next = DIV_LOAD;
    endcase
    if (cfg_we) div_state_next = DIV_LOAD;
  end

  always_comb begin
    unique case (div_state)
      DIV_DONE: div_ready = 1'b1;
      default:  div_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) div_state <= DIV_LOAD;
    else     div_state <= div_state_next;
  end

  always_ff @(posedge clk) begin
    if (div_state == DIV_LOAD) begin
      div_rem <= '0;
      div_quo <= {(nd[15] ? 15'(-nd) : nd[14:0]), 16'b0};
      div_neg <= nd[15];
      div_cnt <= '0;
    end else if (div_state == DIV_RUN) begin
      div_rem <= rem_ge ? 16'(rem_sh - {1'b0, a_eff}) : rem_sh[15:0];
      div_quo <= quo_next;
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == 5'd30) e_lq <= div_neg ? -$signed({1'b0, quo_next}) : {1'b0, quo_next};
    end
  end

  // pipeline control
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv          = !vld[NSTG-1] || result.ready;
  assign sample.ready = adv && div_ready;

  always_ff @(posedge clk) begin
    if (rst)      vld <= '0;
    else if (adv) vld <= {vld[NSTG-2:0], sample.valid && div_ready};
  end

  // product k*rate and first logarithm
  logic [31:0] rate0;
  logic [63:0] p1, p2;
  logic [5:0]  m2r;
  logic        pz2;
  logic [63:0] p2n;
  logic [31:0] l1_z [0:16];
  logic [15:0] l1_f [0:16];
  l1_side_t    l1_sd [0:16];

  assign p2n = p2 << (6'd63 - m2r);

  always_ff @(posedge clk) begin
    if (adv) begin
      rate0    <= sample.data.shear_rate;
      p1       <= {32'b0, time_constant} * {32'b0, rate0};
      p2       <= p1;
      m2r      <= lod64(p1);
      pz2      <= p1 == '0;
      l1_z[0]  <= p2n[63:32];
      l1_f[0]  <= '0;
      l1_sd[0] <= '{pz: pz2, m: m2r};
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_l1
    logic [32:0] nx;
    assign nx = log_step(l1_z[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        l1_z[k]  <= nx[31:0];
        l1_f[k]  <= {l1_f[k-1][14:0], nx[32]};
        l1_sd[k] <= l1_sd[k-1];
      end
    end
  end

  // y1 = floor(a * lx / 2^12), then 2^-|y1|
  logic signed [23:0] lx;
  logic signed [40:0] ap;
  logic               ap_pz;
  logic signed [28:0] y1c;
  logic [27:0]        ymag;
  logic [30:0]        e1_r [1:16];
  logic [15:0]        e1_g [0:16];
  e1_side_t           e1_sd [0:16];

  assign lx   = $signed({2'b0, l1_sd[16].m, l1_f[16]}) - LX_OFF;
  assign y1c  = 29'(ap >>> 12);
  assign ymag = y1c[28] ? 28'(-y1c) : y1c[27:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      ap       <= $signed({1'b0, a_eff}) * lx;
      ap_pz    <= l1_sd[16].pz;
      e1_g[0]  <= 16'(17'h1_0000 - {1'b0, ymag[15:0]});
      e1_sd[0] <= '{pz: ap_pz,
                    ypos: (!y1c[28] && y1c != '0) ? y1c[27:0] : '0,
                    uzero: ymag[27:16] >= 12'd62,
                    ufz: ymag[15:0] == '0,
                    ui: ymag[21:16]};
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_e1
    localparam logic [30:0] COEF = exp2_coef(k);
    logic [30:0] rp;
    if (k == 1) begin : g_first
      assign rp = R_ONE;
    end else begin : g_rest
      assign rp = e1_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        e1_r[k]  <= exp_step(rp, COEF, e1_g[k-1][16-k]);
        e1_g[k]  <= e1_g[k-1];
        e1_sd[k] <= e1_sd[k-1];
      end
    end
  end

  // second logarithm on 2^62 + u
  logic [63:0] u;
  logic [63:0] v2;
  logic        v2_pz;
  logic [27:0] v2_ypos;
  logic [31:0] l2_z [0:16];
  logic [15:0] l2_f [0:16];
  l2_side_t    l2_sd [0:16];

  always_comb begin
    if (e1_sd[16].uzero) u = '0;
    else if (e1_sd[16].ufz) u = 64'd1 << (6'd62 - e1_sd[16].ui);
    else if (e1_sd[16].ui <= 6'd31) u = {33'b0, e1_r[16]} << (6'd31 - e1_sd[16].ui);
    else u = {33'b0, e1_r[16]} >> (e1_sd[16].ui - 6'd31);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v2       <= 64'h4000_0000_0000_0000 + u;
      v2_pz    <= e1_sd[16].pz;
      v2_ypos  <= e1_sd[16].ypos;
      l2_z[0]  <= v2[63] ? v2[63:32] : v2[62:31];
      l2_f[0]  <= '0;
      l2_sd[0] <= '{pz: v2_pz, ypos: v2_ypos, m63: v2[63]};
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_l2
    logic [32:0] nx;
    assign nx = log_step(l2_z[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        l2_z[k]  <= nx[31:0];
        l2_f[k]  <= {l2_f[k-1][14:0], nx[32]};
        l2_sd[k] <= l2_sd[k-1];
      end
    end
  end

  // y2 = floor(e * L2 / 2^16), split into shift and fraction
  logic [27:0]        l2v;
  logic signed [63:0] pr2;
  logic signed [31:0] ip;
  logic signed [32:0] sh;
  logic signed [32:0] nsh;
  logic [30:0]        e2_r [1:16];
  logic [15:0]        e2_g [0:16];
  e2_side_t           e2_sd [0:16];

  assign ip  = pr2[63:32];
  assign sh  = $signed({ip[31], ip}) - 33'sd30;
  assign nsh = -sh;

  always_ff @(posedge clk) begin
    if (adv) begin
      l2v      <= l2_sd[16].pz ? '0 : l2_sd[16].ypos + 28'({l2_sd[16].m63, l2_f[16]});
      pr2      <= e_lq * $signed({1'b0, l2v});
      e2_g[0]  <= pr2[31:16];
      if (sh[32]) begin
        e2_sd[0] <= '{left: 1'b0, over: nsh >= 33'sd64, amt: nsh[5:0]};
      end else begin
        e2_sd[0] <= '{left: 1'b1, over: sh >= 33'sd41, amt: sh[5:0]};
      end
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_e2
    localparam logic [30:0] COEF = exp2_coef(k);
    logic [30:0] rp;
    if (k == 1) begin : g_first
      assign rp = R_ONE;
    end else begin : g_rest
      assign rp = e2_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        e2_r[k]  <= exp_step(rp, COEF, e2_g[k-1][16-k]);
        e2_g[k]  <= e2_g[k-1];
        e2_sd[k] <= e2_sd[k-1];
      end
    end
  end

  // term = |eta_zero - eta_inf| * factor, capped, then the final sum
  logic [63:0]        mag;
  e2_side_t           mag_sd;
  logic [80:0]        wide_c, wide;
  logic               wcap_c, wcap;
  logic [40:0]        term;
  logic signed [42:0] rs;
  out_t               out_q;

  always_comb begin
    wide_c = '0;
    wcap_c = 1'b0;
    if (mag_sd.left) begin
      if (mag_sd.over || mag[63:41] != '0) wcap_c = mag != '0;
      else wide_c = {40'b0, mag[40:0]} << mag_sd.amt;
    end else if (!mag_sd.over) begin
      wide_c = {17'b0, mag >> mag_sd.amt};
    end
  end

  assign rs = dneg ? $signed({11'b0, eta_inf}) - $signed({2'b0, term})
                   : $signed({11'b0, eta_inf}) + $signed({2'b0, term});

  always_ff @(posedge clk) begin
    if (adv) begin
      mag    <= {32'b0, dmag} * {33'b0, e2_r[16]};
      mag_sd <= e2_sd[16];
      wide   <= wide_c;
      wcap   <= wcap_c;
      term   <= (wcap || wide > 81'(TERM_CAP)) ? TERM_CAP : wide[40:0];
      if (rs[42]) out_q <= '{viscosity: '0, saturated: 1'b0};
      else if (rs[41:32] != '0) out_q <= '{viscosity: '1, saturated: 1'b1};
      else out_q <= '{viscosity: rs[31:0], saturated: 1'b0};
    end
  end

  assign result.valid = vld[NSTG-1];
  assign result.data  = out_q;

endmodule

// ===== rtl/cyv_checker.sv =====
// Port-level assertions for carreau_yasuda_viscosity_unit, attached by bind.
// Depends on cyv_pkg for the payload types.
module cyv_checker
  import cyv_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic sample_valid,
  input logic sample_ready,
  input in_t  sample_data,
  input logic result_valid,
  input logic result_ready,
  input out_t result_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.saturated |-> result_data.viscosity == '1)
    else $error("saturated flag without full-scale viscosity");

  a_cfg_hold: assert property (@(posedge clk) cfg_we || rst |=> !sample_ready)
    else $error("input taken while exponent quotient is stale");

  a_rst_out: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !(sample_valid && sample_ready))
    else $error("transfer accepted right after reset");

endmodule

bind carreau_yasuda_viscosity_unit cyv_checker u_cyv_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .sample_data  (sample.data),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
